[rtl/core/eight_step_note_sequencer_unit_macros.svh]
// assertion macros for the sequencer checker
`ifndef EIGHT_STEP_NOTE_SEQUENCER_UNIT_MACROS_SVH
`define EIGHT_STEP_NOTE_SEQUENCER_UNIT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ESNS_CHK_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define ESNS_CHK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/esns_pkg.sv]
package esns_pkg;

   localparam int STEP_COUNT = 8;
   localparam int NOTE_COUNT = 36;
   localparam int NOTE_W     = 6;
   localparam int POS_W      = 3;
   localparam int PERIOD_W   = 15;
   localparam int DIV_W      = 32;
   localparam int DVS_W      = 10;

   localparam logic [1:0] MODE_STOP  = 2'd0;
   localparam logic [1:0] MODE_PLAY  = 2'd1;
   localparam logic [1:0] MODE_PAUSE = 2'd2;

   localparam logic [1:0] MIDI_NONE = 2'd0;
   localparam logic [1:0] MIDI_OFF  = 2'd1;
   localparam logic [1:0] MIDI_ON   = 2'd2;

   localparam logic [1:0] BUZ_KEEP  = 2'd0;
   localparam logic [1:0] BUZ_SIL   = 2'd1;
   localparam logic [1:0] BUZ_CONT  = 2'd2;
   localparam logic [1:0] BUZ_SHORT = 2'd3;

   localparam logic [2:0] CSR_DCLICK = 3'd0;
   localparam logic [2:0] CSR_BPMMIN = 3'd1;
   localparam logic [2:0] CSR_BPMMAX = 3'd2;
   localparam logic [2:0] CSR_BASE   = 3'd3;
   localparam logic [2:0] CSR_FLASH  = 3'd4;
   localparam logic [2:0] CSR_BLINK  = 3'd5;

   typedef struct packed {
      logic capture;
      logic apply;
      logic div_start;
      logic div_sel;     // 0 step period, 1 blink phase
      logic step;
      logic out_second;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic tempo_dirty;
      logic two_msgs;
   } status_type;

   function automatic logic [9:0] freq_of(input logic [NOTE_W-1:0] note);
      logic [9:0] hz;
      case (note)
         6'd0:  hz = 10'd131;  6'd1:  hz = 10'd139;  6'd2:  hz = 10'd147;
         6'd3:  hz = 10'd156;  6'd4:  hz = 10'd165;  6'd5:  hz = 10'd175;
         6'd6:  hz = 10'd185;  6'd7:  hz = 10'd196;  6'd8:  hz = 10'd208;
         6'd9:  hz = 10'd220;  6'd10: hz = 10'd233;  6'd11: hz = 10'd247;
         6'd12: hz = 10'd262;  6'd13: hz = 10'd277;  6'd14: hz = 10'd294;
         6'd15: hz = 10'd311;  6'd16: hz = 10'd330;  6'd17: hz = 10'd349;
         6'd18: hz = 10'd370;  6'd19: hz = 10'd392;  6'd20: hz = 10'd415;
         6'd21: hz = 10'd440;  6'd22: hz = 10'd466;  6'd23: hz = 10'd494;
         6'd24: hz = 10'd523;  6'd25: hz = 10'd554;  6'd26: hz = 10'd587;
         6'd27: hz = 10'd622;  6'd28: hz = 10'd659;  6'd29: hz = 10'd698;
         6'd30: hz = 10'd740;  6'd31: hz = 10'd784;  6'd32: hz = 10'd831;
         6'd33: hz = 10'd880;  6'd34: hz = 10'd932;
         default: hz = 10'd988;
      endcase
      return hz;
   endfunction

endpackage

[rtl/core/eight_step_note_sequencer_unit.sv]
// eight-step note sequencer, one request per millisecond of sampled controls
// request channel: req_valid / req_stall carry the debounced buttons, the
//   encoder delta and the three step masks; taken when valid and not stall
// result channel: rsp_valid / rsp_stall carry midi message, buzzer command,
//   transport, step, tempo, pattern and leds; rsp_last closes a request
// each request gives one result, or two when a note off and a note on
//   are sent together
// csr channel: csr_valid / csr_ready with csr_index and csr_data, always
//   ready; write only between requests
// timing: one request at a time; the request is captured and decoded, then
//   the shared restoring divider makes one pass for the blink phase, hands
//   off its quotient, and the step logic runs; a tempo change first adds a
//   pass for the step period and its hand-off; the first result is then
//   offered, and rsp_stall may hold it
// overlap: a new request is taken only after the last result of the one
//   before it has been taken
// req_stall stays high from the taking of a request until its last result
//   is taken, and during reset; a stalled result holds its payload
// reset: synchronous, active high; state registers go to their defaults, stop
//   mode, tempo 165, step 0, all steps enabled, no note sounding
module eight_step_note_sequencer_unit (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_play_press,
   input  logic              req_forward_press,
   input  logic              req_back_level,
   input  logic signed [4:0] req_encoder_delta,
   input  logic [7:0]        req_held_mask,
   input  logic [7:0]        req_pressed_mask,
   input  logic [7:0]        req_released_mask,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_midi_kind,
   output logic [6:0]        rsp_midi_note,
   output logic [6:0]        rsp_midi_velocity,
   output logic [1:0]        rsp_buzzer_cmd,
   output logic [9:0]        rsp_buzzer_hz,
   output logic [1:0]        rsp_transport,
   output logic [2:0]        rsp_step_index,
   output logic [7:0]        rsp_tempo_bpm,
   output logic [7:0]        rsp_pattern_mask,
   output logic              rsp_led_red,
   output logic              rsp_led_green,
   output logic              rsp_last,
   // csr write channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [9:0]        csr_data
);

   esns_pkg::cmd_type    cmd;
   esns_pkg::status_type status;

   // register file never blocks
   assign csr_ready = 1'b1;

   // sequencing of one request: capture, decode, divide, step, deliver
   esns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // sequencer state, divider and result formatting
   esns_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_play_press    (req_play_press),
      .req_forward_press (req_forward_press),
      .req_back_level    (req_back_level),
      .req_encoder_delta (req_encoder_delta),
      .req_held_mask     (req_held_mask),
      .req_pressed_mask  (req_pressed_mask),
      .req_released_mask (req_released_mask),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_midi_kind     (rsp_midi_kind),
      .rsp_midi_note     (rsp_midi_note),
      .rsp_midi_velocity (rsp_midi_velocity),
      .rsp_buzzer_cmd    (rsp_buzzer_cmd),
      .rsp_buzzer_hz     (rsp_buzzer_hz),
      .rsp_transport     (rsp_transport),
      .rsp_step_index    (rsp_step_index),
      .rsp_tempo_bpm     (rsp_tempo_bpm),
      .rsp_pattern_mask  (rsp_pattern_mask),
      .rsp_led_red       (rsp_led_red),
      .rsp_led_green     (rsp_led_green),
      .rsp_last          (rsp_last)
   );

endmodule

[rtl/core/esns_ctrl.sv]
module esns_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  esns_pkg::status_type   status,
   output esns_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_APPLY = 3'd1;
   localparam logic [2:0] ST_SEL   = 3'd2;
   localparam logic [2:0] ST_DIVP  = 3'd3;
   localparam logic [2:0] ST_DIVB  = 3'd4;
   localparam logic [2:0] ST_STEP  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       second_ff, second_in;
   logic       rsp_take;

   // no request is taken while reset is high
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_take  = rsp_valid && !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      cmd       = '0;
      cmd.out_second = second_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_SEL;
         end
         ST_SEL: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = !status.tempo_dirty;
            state_in      = status.tempo_dirty ? ST_DIVP : ST_DIVB;
         end
         ST_DIVP: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = 1'b1;
               state_in      = ST_DIVB;
            end
         end
         ST_DIVB: begin
            if (status.div_done) state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.step  = 1'b1;
            second_in = 1'b0;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_take) begin
               if (status.two_msgs && !second_ff) begin
                  second_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

endmodule

[rtl/core/esns_datapath.sv]
module esns_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  esns_pkg::cmd_type      cmd,
   output esns_pkg::status_type   status,
   input  logic                   req_play_press,
   input  logic                   req_forward_press,
   input  logic                   req_back_level,
   input  logic signed [4:0]      req_encoder_delta,
   input  logic [7:0]             req_held_mask,
   input  logic [7:0]             req_pressed_mask,
   input  logic [7:0]             req_released_mask,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [9:0]             csr_data,
   output logic [1:0]             rsp_midi_kind,
   output logic [6:0]             rsp_midi_note,
   output logic [6:0]             rsp_midi_velocity,
   output logic [1:0]             rsp_buzzer_cmd,
   output logic [9:0]             rsp_buzzer_hz,
   output logic [1:0]             rsp_transport,
   output logic [2:0]             rsp_step_index,
   output logic [7:0]             rsp_tempo_bpm,
   output logic [7:0]             rsp_pattern_mask,
   output logic                   rsp_led_red,
   output logic                   rsp_led_green,
   output logic                   rsp_last
);

   localparam int SC = esns_pkg::STEP_COUNT;
   localparam int NW = esns_pkg::NOTE_W;
   localparam int PW = esns_pkg::PERIOD_W;
   localparam int DW = esns_pkg::DIV_W;
   localparam int VW = esns_pkg::DVS_W;

   // configuration
   logic [9:0] dclick_ff, flash_ff, blink_ff;
   logic [7:0] bpm_min_ff, bpm_max_ff;
   logic [6:0] base_ff;

   // captured request
   logic             play_ff, fwd_ff, back_ff;
   logic signed [4:0] delta_ff;
   logic [7:0]       held_ff, pressed_ff, released_ff;

   // sequencer state
   logic [1:0]    mode_ff, mode_in;
   logic [2:0]    pos_ff, pos_in;
   logic [7:0]    tempo_ff, tempo_in;
   logic [PW-1:0] period_ff, period_in;
   logic [PW-1:0] since_step_ff, since_step_in;
   logic [31:0]   ms_clock_ff;
   logic          await_ff, await_in;
   logic [9:0]    since_click_ff, since_click_in;
   logic [NW-1:0] note_ff [SC], note_in [SC];
   logic [SC-1:0] enabled_ff, enabled_in;
   logic [SC-1:0] tuned_ff, tuned_in;
   logic          sv_ff, sv_in;
   logic [6:0]    snote_ff, snote_in;
   logic          back_prev_ff, back_prev_in;
   logic [4:0]    back_hold_ff, back_hold_in;
   logic          dirty_ff, dirty_in;

   // per-item results
   logic [1:0] mcnt_ff, mcnt_in;
   logic [1:0] mkind_ff [2], mkind_in [2];
   logic [6:0] mnote_ff [2], mnote_in [2];
   logic [1:0] buzc_ff, buzc_in;
   logic [9:0] buzh_ff, buzh_in;
   logic       red_ff, red_in, green_ff, green_in;

   // shared restoring divider
   logic          dbusy_ff;
   logic          ddone_ff;
   logic          dsel_ff;
   logic [4:0]    dcnt_ff;
   logic [DW-1:0] dq_ff;
   logic [VW:0]   drem_ff;
   logic [VW-1:0] dvs_ff;
   logic [VW:0]   drem_sh;
   logic [VW:0]   drem_nx;
   logic          dq_bit;
   logic          blink_bit_ff;

   logic signed [7:0]  n_sum;
   logic signed [10:0] t_sum;
   logic [7:0]         n_mid;
   logic [7:0]         base_sum;
   logic               tuning;
   logic               adv;
   logic               sel_msg;

   always_comb begin
      drem_sh = {drem_ff[VW-1:0], dq_ff[DW-1]};
      dq_bit  = (drem_sh >= {1'b0, dvs_ff});
      drem_nx = dq_bit ? (drem_sh - {1'b0, dvs_ff}) : drem_sh;
   end

   // item processing: apply phase and step phase
   always_comb begin
      mode_in        = mode_ff;
      pos_in         = pos_ff;
      tempo_in       = tempo_ff;
      since_step_in  = since_step_ff;
      await_in       = await_ff;
      since_click_in = since_click_ff;
      note_in        = note_ff;
      enabled_in     = enabled_ff;
      tuned_in       = tuned_ff;
      sv_in          = sv_ff;
      snote_in       = snote_ff;
      back_prev_in   = back_prev_ff;
      back_hold_in   = back_hold_ff;
      dirty_in       = dirty_ff;
      mcnt_in        = mcnt_ff;
      mkind_in       = mkind_ff;
      mnote_in       = mnote_ff;
      buzc_in        = buzc_ff;
      buzh_in        = buzh_ff;
      red_in         = red_ff;
      green_in       = green_ff;
      tuning         = 1'b0;
      n_sum          = '0;
      n_mid          = '0;
      t_sum          = '0;
      base_sum       = '0;
      adv            = 1'b0;

      if (cmd.apply) begin
         mcnt_in  = 2'd0;
         buzc_in  = esns_pkg::BUZ_KEEP;
         buzh_in  = '0;
         dirty_in = 1'b0;
         // transport button
         if (play_ff) begin
            if (await_ff && (since_click_ff < dclick_ff)) begin
               mode_in = esns_pkg::MODE_STOP;
               pos_in  = '0;
               buzc_in = esns_pkg::BUZ_SIL;
               if (sv_ff) begin
                  mcnt_in     = 2'd1;
                  mkind_in[0] = esns_pkg::MIDI_OFF;
                  mnote_in[0] = snote_ff;
               end
               sv_in    = 1'b0;
               await_in = 1'b0;
            end else begin
               if (mode_ff == esns_pkg::MODE_PLAY) begin
                  mode_in = esns_pkg::MODE_PAUSE;
                  buzc_in = esns_pkg::BUZ_SIL;
                  if (sv_ff) begin
                     mcnt_in     = 2'd1;
                     mkind_in[0] = esns_pkg::MIDI_OFF;
                     mnote_in[0] = snote_ff;
                  end
                  sv_in = 1'b0;
               end else begin
                  mode_in       = esns_pkg::MODE_PLAY;
                  since_step_in = period_ff;
               end
               await_in       = 1'b1;
               since_click_in = '0;
            end
         end
         if (await_in && (since_click_in >= dclick_ff)) await_in = 1'b0;

         // manual stepping in pause
         if (mode_in == esns_pkg::MODE_PAUSE) begin
            if (fwd_ff) begin
               pos_in = pos_in + 3'd1;
               if (enabled_ff[pos_in]) begin
                  buzc_in = esns_pkg::BUZ_SHORT;
                  buzh_in = esns_pkg::freq_of(note_ff[pos_in]);
               end
            end
            if ((back_ff != back_prev_ff) && (back_hold_ff > 5'd15)) begin
               if (back_ff) begin
                  pos_in = pos_in - 3'd1;
                  if (enabled_ff[pos_in]) begin
                     buzc_in = esns_pkg::BUZ_SHORT;
                     buzh_in = esns_pkg::freq_of(note_ff[pos_in]);
                  end
               end
               back_prev_in = back_ff;
               back_hold_in = '0;
            end
         end

         // encoder: retune held steps or change tempo
         if (delta_ff != 5'sd0) begin
            tuning = |held_ff;
            for (int i = 0; i < SC; i++) begin
               if (held_ff[i]) begin
                  n_sum = $signed({2'b00, note_ff[i]}) + 8'(delta_ff);
                  if (n_sum < 8'sd0) n_mid = '0;
                  else if (n_sum > 8'(esns_pkg::NOTE_COUNT - 1))
                     n_mid = 8'(esns_pkg::NOTE_COUNT - 1);
                  else n_mid = n_sum;
                  note_in[i]  = n_mid[NW-1:0];
                  tuned_in[i] = 1'b1;
                  if (mode_in != esns_pkg::MODE_PLAY) begin
                     buzc_in = esns_pkg::BUZ_SHORT;
                     buzh_in = esns_pkg::freq_of(n_mid[NW-1:0]);
                  end
               end
            end
            if (!tuning) begin
               t_sum = $signed({3'b000, tempo_ff}) + 11'(delta_ff) * 11'sd2;
               if (t_sum < $signed({3'b000, bpm_min_ff})) t_sum = $signed({3'b000, bpm_min_ff});
               if (t_sum > $signed({3'b000, bpm_max_ff})) t_sum = $signed({3'b000, bpm_max_ff});
               if (t_sum < 11'sd1) t_sum = 11'sd1;
               tempo_in = t_sum[7:0];
               dirty_in = 1'b1;
            end
         end

         // step buttons
         for (int i = 0; i < SC; i++) begin
            if (pressed_ff[i]) tuned_in[i] = 1'b0;
            if (released_ff[i] && !tuned_in[i]) enabled_in[i] = !enabled_ff[i];
         end
      end

      if (cmd.step) begin
         adv = (mode_ff == esns_pkg::MODE_PLAY) && (since_step_ff >= period_ff);
         if (adv) begin
            pos_in        = pos_ff + 3'd1;
            since_step_in = '0;
            if (sv_ff && (mcnt_ff < 2'd2)) begin
               mkind_in[mcnt_ff[0]] = esns_pkg::MIDI_OFF;
               mnote_in[mcnt_ff[0]] = snote_ff;
               mcnt_in              = mcnt_ff + 2'd1;
            end
            sv_in = 1'b0;
            if (enabled_ff[pos_in]) begin
               base_sum = {1'b0, base_ff} + {2'b00, note_ff[pos_in]};
               snote_in = base_sum[7] ? 7'd127 : base_sum[6:0];
               sv_in    = 1'b1;
               buzc_in  = esns_pkg::BUZ_CONT;
               buzh_in  = esns_pkg::freq_of(note_ff[pos_in]);
               if (mcnt_in < 2'd2) begin
                  mkind_in[mcnt_in[0]] = esns_pkg::MIDI_ON;
                  mnote_in[mcnt_in[0]] = snote_in;
                  mcnt_in              = mcnt_in + 2'd1;
               end
            end else begin
               buzc_in = esns_pkg::BUZ_SIL;
               buzh_in = '0;
            end
         end
         if (mode_ff == esns_pkg::MODE_STOP) begin
            red_in   = 1'b1;
            green_in = 1'b0;
         end else if (mode_ff == esns_pkg::MODE_PAUSE) begin
            red_in   = blink_bit_ff;
            green_in = blink_bit_ff;
         end else begin
            red_in   = 1'b0;
            green_in = enabled_ff[pos_in] && (since_step_in < PW'(flash_ff));
         end
         // counters advance at the end of every item
         if (since_step_in != {PW{1'b1}}) since_step_in = since_step_in + PW'(1);
         if (since_click_ff != 10'd1023) since_click_in = since_click_ff + 10'd1;
         if (back_hold_ff != 5'd31) back_hold_in = back_hold_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dclick_ff      <= 10'd300;
         bpm_min_ff     <= 8'd60;
         bpm_max_ff     <= 8'd240;
         base_ff        <= 7'd48;
         flash_ff       <= 10'd100;
         blink_ff       <= 10'd500;
         mode_ff        <= esns_pkg::MODE_STOP;
         pos_ff         <= '0;
         tempo_ff       <= 8'd165;
         period_ff      <= PW'(181);
         since_step_ff  <= '0;
         ms_clock_ff    <= '0;
         await_ff       <= 1'b0;
         since_click_ff <= '0;
         note_ff[0] <= NW'(4);  note_ff[1] <= NW'(7);
         note_ff[2] <= NW'(9);  note_ff[3] <= NW'(11);
         note_ff[4] <= NW'(12); note_ff[5] <= NW'(14);
         note_ff[6] <= NW'(16); note_ff[7] <= NW'(14);
         enabled_ff     <= '1;
         tuned_ff       <= '0;
         sv_ff          <= 1'b0;
         back_prev_ff   <= 1'b0;
         back_hold_ff   <= '0;
         dirty_ff       <= 1'b0;
         mcnt_ff        <= '0;
         dbusy_ff       <= 1'b0;
         ddone_ff       <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               esns_pkg::CSR_DCLICK: dclick_ff  <= csr_data;
               esns_pkg::CSR_BPMMIN: bpm_min_ff <= csr_data[7:0];
               esns_pkg::CSR_BPMMAX: bpm_max_ff <= csr_data[7:0];
               esns_pkg::CSR_BASE:   base_ff    <= csr_data[6:0];
               esns_pkg::CSR_FLASH:  flash_ff   <= csr_data;
               esns_pkg::CSR_BLINK:  blink_ff   <= csr_data;
               default: ;
            endcase
         end
         mode_ff        <= mode_in;
         pos_ff         <= pos_in;
         tempo_ff       <= tempo_in;
         since_step_ff  <= since_step_in;
         await_ff       <= await_in;
         since_click_ff <= since_click_in;
         note_ff        <= note_in;
         enabled_ff     <= enabled_in;
         tuned_ff       <= tuned_in;
         sv_ff          <= sv_in;
         back_prev_ff   <= back_prev_in;
         back_hold_ff   <= back_hold_in;
         dirty_ff       <= dirty_in;
         mcnt_ff        <= mcnt_in;
         if (cmd.step) ms_clock_ff <= ms_clock_ff + 32'd1;
         // divider control
         ddone_ff <= 1'b0;
         if (cmd.div_start) begin
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff && (dcnt_ff == 5'd31)) begin
            dbusy_ff <= 1'b0;
            ddone_ff <= 1'b1;
         end
         if (ddone_ff && !dsel_ff) period_ff <= dq_ff[PW-1:0];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      snote_ff <= snote_in;
      mkind_ff <= mkind_in;
      mnote_ff <= mnote_in;
      buzc_ff  <= buzc_in;
      buzh_ff  <= buzh_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      if (cmd.capture) begin
         play_ff     <= req_play_press;
         fwd_ff      <= req_forward_press;
         back_ff     <= req_back_level;
         delta_ff    <= req_encoder_delta;
         held_ff     <= req_held_mask;
         pressed_ff  <= req_pressed_mask;
         released_ff <= req_released_mask;
      end
      if (cmd.div_start) begin
         dsel_ff <= cmd.div_sel;
         dcnt_ff <= '0;
         drem_ff <= '0;
         if (cmd.div_sel) begin
            dq_ff  <= ms_clock_ff;
            dvs_ff <= (blink_ff == '0) ? VW'(1) : blink_ff;
         end else begin
            dq_ff  <= DW'(30000);
            dvs_ff <= {2'b00, tempo_ff};
         end
      end else if (dbusy_ff) begin
         dcnt_ff <= dcnt_ff + 5'd1;
         drem_ff <= drem_nx;
         dq_ff   <= {dq_ff[DW-2:0], dq_bit};
      end
      if (ddone_ff && dsel_ff) blink_bit_ff <= dq_ff[0];
   end

   assign status.div_done    = ddone_ff;
   assign status.tempo_dirty = dirty_ff;
   assign status.two_msgs    = (mcnt_ff == 2'd2);

   // result selection: one result per message, or one empty result
   assign sel_msg = cmd.out_second ? (mcnt_ff == 2'd2) : (mcnt_ff != 2'd0);
   assign rsp_last          = cmd.out_second || (mcnt_ff != 2'd2);
   assign rsp_midi_kind     = sel_msg ? mkind_ff[cmd.out_second] : esns_pkg::MIDI_NONE;
   assign rsp_midi_note     = sel_msg ? mnote_ff[cmd.out_second] : '0;
   assign rsp_midi_velocity = (rsp_midi_kind == esns_pkg::MIDI_ON) ? 7'd127 : 7'd0;
   assign rsp_buzzer_cmd    = rsp_last ? buzc_ff : esns_pkg::BUZ_KEEP;
   assign rsp_buzzer_hz     = rsp_last ? buzh_ff : '0;
   assign rsp_transport     = mode_ff;
   assign rsp_step_index    = pos_ff;
   assign rsp_tempo_bpm     = tempo_ff;
   assign rsp_pattern_mask  = enabled_ff;
   assign rsp_led_red       = red_ff;
   assign rsp_led_green     = green_ff;

endmodule

[rtl/core/esns_checker.sv]
`include "eight_step_note_sequencer_unit_macros.svh"

module esns_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_last,
   input logic [1:0] rsp_midi_kind
);

   `ESNS_CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `ESNS_CHK_SAME(a_no_overlap, req_valid && !req_stall, !rsp_valid, "request taken with result pending")
   `ESNS_CHK_NEXT(a_last_ends, rsp_valid && !rsp_stall && rsp_last, !rsp_valid, "result after last")
   `ESNS_CHK_SAME(a_empty_last, rsp_valid && (rsp_midi_kind == esns_pkg::MIDI_NONE), rsp_last, "empty result not last")

endmodule

bind eight_step_note_sequencer_unit esns_checker u_esns_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_last      (rsp_last),
   .rsp_midi_kind (rsp_midi_kind)
);
